// File: hw/rtl/qhd_pkg.sv
`default_nettype none

package qhd_pkg;

    // Default width of one received sample component (Q3.12 at 16 bits)
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Threshold compare width floor: thresholds fit in 16 signed bits
    localparam int THR_W = 16;

    // Configuration codes of mod_order
    localparam logic [1:0] MOD_QPSK  = 2'd0;
    localparam logic [1:0] MOD_16QAM = 2'd1;
    localparam logic [1:0] MOD_64QAM = 2'd2;

    // Number of index bits held for the largest constellation
    localparam int SYM_BITS = 6;

    // Decision thresholds per axis: the sum of two adjacent levels, compared
    // against twice the sample. Strictly greater picks the upper level, so a
    // tie resolves toward the lower level index.
    localparam logic signed [THR_W-1:0] THR_QPSK = 16'sd0;
    localparam logic signed [THR_W-1:0] THR_16 [3] = '{
        -16'sd5181, 16'sd0, 16'sd5181
    };
    localparam logic signed [THR_W-1:0] THR_64 [7] = '{
        -16'sd7584, -16'sd5056, -16'sd2528, 16'sd0,
        16'sd2528, 16'sd5056, 16'sd7584
    };

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/qhd_datapath.sv
`default_nettype none

module qhd_datapath #(
    parameter int SAMPLE_WIDTH = qhd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire        [1:0]               i_cfg_data,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_sample_i,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_sample_q,
    input  qhd_pkg::t_dp_cmd               i_cmd,
    output qhd_pkg::t_dp_sts               o_sts,
    output logic                           o_bit_value,
    output logic                           o_last_bit
);

    localparam int CMP_W = (SAMPLE_WIDTH + 1 > qhd_pkg::THR_W) ?
                           SAMPLE_WIDTH + 1 : qhd_pkg::THR_W;

    logic [1:0]                     r_mod;
    logic [qhd_pkg::SYM_BITS-1:0]   r_bits;
    logic [qhd_pkg::SYM_BITS-1:0]   n_bits;
    logic [2:0]                     r_left;
    logic [2:0]                     n_left;
    logic signed [CMP_W-1:0]        w_i2;
    logic signed [CMP_W-1:0]        w_q2;
    logic [2:0]                     w_lvl_i;
    logic [2:0]                     w_lvl_q;

    // Count thresholds below twice the sample: gives the nearest level index
    function automatic logic [2:0] f_level(input logic signed [CMP_W-1:0] v,
                                           input logic [1:0] m);
        logic [2:0] cnt;
        cnt = 3'd0;
        case (m)
            qhd_pkg::MOD_QPSK: begin
                if (v > CMP_W'(qhd_pkg::THR_QPSK)) cnt = 3'd1;
            end
            qhd_pkg::MOD_16QAM: begin
                for (int k = 0; k < 3; k++) begin
                    if (v > CMP_W'(qhd_pkg::THR_16[k])) cnt = cnt + 3'd1;
                end
            end
            default: begin
                for (int k = 0; k < 7; k++) begin
                    if (v > CMP_W'(qhd_pkg::THR_64[k])) cnt = cnt + 3'd1;
                end
            end
        endcase
        return cnt;
    endfunction

    assign w_i2    = CMP_W'($signed({i_sample_i, 1'b0}));
    assign w_q2    = CMP_W'($signed({i_sample_q, 1'b0}));
    assign w_lvl_i = f_level(w_i2, r_mod);
    assign w_lvl_q = f_level(w_q2, r_mod);

    always_comb begin
        n_bits = r_bits;
        n_left = r_left;
        if (i_cmd.load) begin
            case (r_mod)
                qhd_pkg::MOD_QPSK: begin
                    n_bits = {w_lvl_i[0], w_lvl_q[0], 4'b0000};
                    n_left = 3'd1;
                end
                qhd_pkg::MOD_16QAM: begin
                    n_bits = {w_lvl_i[1:0], w_lvl_q[1:0], 2'b00};
                    n_left = 3'd3;
                end
                default: begin
                    n_bits = {w_lvl_i, w_lvl_q};
                    n_left = 3'd5;
                end
            endcase
        end else if (i_cmd.shift) begin
            n_bits = {r_bits[qhd_pkg::SYM_BITS-2:0], 1'b0};
            n_left = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= qhd_pkg::MOD_QPSK;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_left <= n_left;
    end

    assign o_bit_value = r_bits[qhd_pkg::SYM_BITS-1];
    assign o_last_bit  = (r_left == 3'd0);
    assign o_sts.last  = o_last_bit;

endmodule

`default_nettype wire

// File: hw/rtl/qhd_ctrl.sv
`default_nettype none

module qhd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    input  qhd_pkg::t_dp_sts  i_sts,
    output qhd_pkg::t_dp_cmd  o_cmd
);

    qhd_pkg::t_state r_state;
    qhd_pkg::t_state n_state;
    logic            w_out_take;
    logic            w_in_ready;

    always_comb begin
        w_out_take = (r_state == qhd_pkg::ST_SEND) && !i_out_stall;
        w_in_ready = (r_state == qhd_pkg::ST_IDLE) || (w_out_take && i_sts.last);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qhd_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = qhd_pkg::ST_SEND;
            end
            qhd_pkg::ST_SEND: begin
                if (w_out_take && i_sts.last && !i_in_valid) n_state = qhd_pkg::ST_IDLE;
            end
            default: n_state = qhd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall  = !w_in_ready;
        o_out_valid = (r_state == qhd_pkg::ST_SEND);
        o_cmd.load  = w_in_ready && i_in_valid;
        o_cmd.shift = w_out_take && !i_sts.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qhd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/qam_hard_decision_demapper_top.sv
`default_nettype none

// QAM hard-decision demapper. Each input transaction carries one received
// I/Q sample (Q3.12, SAMPLE_WIDTH bits signed) and yields the index of the
// nearest constellation point, emitted MSB first as one output transaction
// per bit with o_last_bit marking the final bit: 2 bits for QPSK, 4 for
// 16-QAM, 6 for 64-QAM (mod_order 0/1/2, code 3 acts as 64-QAM). Labels are
// natural binary: high half selects the I level, low half the Q level,
// levels ascending; a distance tie goes to the lower index. Since the
// squared distance separates per axis, each axis is decided by comparing
// twice the sample against the sums of adjacent levels. The serializer
// emits the bits in order and holds the current bit while the output
// stalls; the next sample is taken in the cycle its predecessor's last bit
// leaves, so symbols stream back to back.
// Write mod_order only while idle.
module qam_hard_decision_demapper_top #(
    parameter int SAMPLE_WIDTH = qhd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration: mod_order
    input  wire                            i_cfg_we,
    input  wire        [1:0]               i_cfg_data,
    // Sample channel
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_sample_i,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_sample_q,
    // Bit channel
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_bit_value,
    output logic                           o_last_bit
);

    qhd_pkg::t_dp_cmd w_cmd;
    qhd_pkg::t_dp_sts w_sts;

    // Sequence loads and shifts against both handshakes
    qhd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Decide levels, hold the index and shift it out
    qhd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_bit_value (o_bit_value),
        .o_last_bit  (o_last_bit)
    );

    // An accepted sample always presents a bit in the next cycle
    a_load_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("no output after accepted sample");

    // Drop to idle after the last bit leaves with no new sample
    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_bit && !i_in_valid) |=> !o_out_valid)
        else $error("output still valid after last bit");

    // Hold off input while bits of the current symbol remain
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !(o_last_bit && !i_out_stall)) |-> o_in_stall)
        else $error("input taken mid-symbol");

endmodule

`default_nettype wire
